### hdl/wbmp_pkg.sv
// Package for the WBMP stream parser: parser phase and status codes,
// the default dimension width and the field masks. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package wbmp_pkg;

  localparam int unsigned DimBitsDef = 16;

  // Bit 7 of a header byte says that more digits follow.
  localparam logic [7:0] ContMask  = 8'h80;
  localparam logic [7:0] DigitMask = 8'h7f;

  // Each digit carries seven bits, so one digit scales the value by 128.
  localparam int unsigned DigitBits = 7;

  localparam int unsigned OutDimBits = 16;

  typedef enum logic [6:0] {
    PH_TYPE   = 7'b0000001,
    PH_FIX    = 7'b0000010,
    PH_WIDTH  = 7'b0000100,
    PH_HEIGHT = 7'b0001000,
    PH_PIXELS = 7'b0010000,
    PH_DONE   = 7'b0100000,
    PH_ERROR  = 7'b1000000
  } phase_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_BAD_TYPE = 3'd1,
    ST_BAD_FIX  = 3'd2,
    ST_TRUNC    = 3'd3,
    ST_OVERFLOW = 3'd4
  } status_e;

endpackage

`default_nettype wire

### hdl/wbmp_stream_parser.sv
// Top level of the WBMP type-0 stream parser: header decode, pixel byte
// pass-through and an output register. Depends on wbmp_pkg and wbmp_dim_acc.
//
// Usage. Bytes of a WBMP file arrive on the slave stream, one item per byte,
// with s_axis_tdata[7:0] holding the byte. An item with s_axis_tlast high
// marks the end of the stream; it carries no byte and rearms the parser.
// Every input item produces exactly one result item on the master stream.
// A result carries the pixel byte (zero when it is not a pixel), the decoded
// width and height, and in tuser the data valid and header done flags and
// the status code. tlast marks the last pixel byte of the frame, or the
// header end of an empty image.
//
// A result is loaded into the output register at the edge that accepts its
// item and is offered on the master stream from the next cycle. One item is
// taken per cycle while the master side does not stall; all the decode work
// is a single shift-add and counter update ahead of that register. The input is
// ready whenever the output register is empty or is being emptied in the
// same cycle, so a stall on the master side holds the waiting result and
// back-pressures the slave side without losing items.
//
// Reset clears the parser to await the type field and empties the output
// register. After an error or a complete frame, bytes are ignored until the
// end-of-stream item, which reports the final status.
`timescale 1ns / 1ps
`default_nettype none

module wbmp_stream_parser
  import wbmp_pkg::*;
#(
  parameter int unsigned DIM_BITS = DimBitsDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Slave stream. tdata: byte_value[7:0]. tlast: stream_end.
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,
  input  wire logic        s_axis_tlast,
  // Master stream. tdata: data_byte[7:0], width[23:8], height[39:24].
  // tuser: data_valid[0], header_done[1], status[4:2]. tlast: frame_done.
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [39:0]      m_axis_tdata,
  output logic [4:0]       m_axis_tuser,
  output logic             m_axis_tlast
);

  // A row of pixels needs ceil(width/8) bytes, which is at most 2^(DIM_BITS-3).
  localparam int unsigned RowBits = DIM_BITS - 2;

  // Parser state.
  phase_e              phase_q, phase_d;
  status_e             err_q, err_d;
  logic [DIM_BITS-1:0] accum_q, accum_d;
  logic [DIM_BITS-1:0] width_q, width_d;
  logic [DIM_BITS-1:0] height_q, height_d;
  logic [RowBits-1:0]  row_cnt_q, row_cnt_d;
  logic [DIM_BITS-1:0] line_cnt_q, line_cnt_d;

  // Result register.
  logic                out_valid_q;
  logic [7:0]          out_byte_q, res_byte;
  logic                out_dvalid_q, res_dvalid;
  logic                out_hdone_q, res_hdone;
  logic                out_fdone_q, res_fdone;
  logic [OutDimBits-1:0] out_width_q, res_width;
  logic [OutDimBits-1:0] out_height_q, res_height;
  status_e             out_status_q, res_status;

  logic                in_acc;
  logic [DIM_BITS-1:0] acc_sum;
  logic                acc_ovf;
  logic [DIM_BITS:0]   row_bytes_w;
  logic [RowBits-1:0]  row_bytes;
  logic [RowBits-1:0]  row_next;
  logic [DIM_BITS-1:0] line_next;
  logic                type_nz;
  logic [DIM_BITS+OutDimBits-1:0] width_ext, height_ext;

  function automatic logic [OutDimBits-1:0] out_width_sel(input logic [DIM_BITS-1:0] v);
    logic [DIM_BITS+OutDimBits-1:0] ext;
    ext = {{OutDimBits{1'b0}}, v};
    return ext[OutDimBits-1:0];
  endfunction

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  wbmp_dim_acc #(
    .DIM_BITS (DIM_BITS)
  ) u_dim_acc (
    .accum_i (accum_q),
    .digit_i (s_axis_tdata[DigitBits-1:0]),
    .sum_o   (acc_sum),
    .ovf_o   (acc_ovf)
  );

  // Bytes per row, rounded up to whole bytes.
  assign row_bytes_w = ({1'b0, width_q} + (DIM_BITS+1)'(7)) >> 3;
  assign row_bytes   = row_bytes_w[RowBits-1:0];
  assign row_next    = row_cnt_q + RowBits'(1);
  assign line_next   = line_cnt_q + DIM_BITS'(1);

  // The type is only ever tracked as zero or not zero.
  assign type_nz = (accum_q != '0) || ((s_axis_tdata & DigitMask) != 8'h00);

  always_comb begin
    phase_d    = phase_q;
    err_d      = err_q;
    accum_d    = accum_q;
    width_d    = width_q;
    height_d   = height_q;
    row_cnt_d  = row_cnt_q;
    line_cnt_d = line_cnt_q;
    res_byte   = 8'h00;
    res_dvalid = 1'b0;
    res_hdone  = 1'b0;
    res_fdone  = 1'b0;
    res_status = ST_OK;

    if (s_axis_tlast) begin
      // End of stream: report how the frame ended, then clear everything.
      if (phase_q == PH_ERROR) begin
        res_status = err_q;
      end else if (phase_q == PH_DONE) begin
        res_status = ST_OK;
      end else begin
        res_status = ST_TRUNC;
      end
      phase_d    = PH_TYPE;
      err_d      = ST_OK;
      accum_d    = '0;
      width_d    = '0;
      height_d   = '0;
      row_cnt_d  = '0;
      line_cnt_d = '0;
    end else begin
      case (phase_q)
        PH_TYPE: begin
          if (type_nz) begin
            accum_d = DIM_BITS'(1);
          end
          if ((s_axis_tdata & ContMask) == 8'h00) begin
            if (type_nz) begin
              phase_d = PH_ERROR;
              err_d   = ST_BAD_TYPE;
            end else begin
              phase_d = PH_FIX;
            end
            accum_d = '0;
          end
        end
        PH_FIX: begin
          if ((s_axis_tdata & ContMask) != 8'h00) begin
            phase_d = PH_ERROR;
            err_d   = ST_BAD_FIX;
          end else begin
            phase_d = PH_WIDTH;
          end
        end
        PH_WIDTH, PH_HEIGHT: begin
          if (acc_ovf) begin
            accum_d = '0;
            phase_d = PH_ERROR;
            err_d   = ST_OVERFLOW;
          end else if ((s_axis_tdata & ContMask) != 8'h00) begin
            accum_d = acc_sum;
          end else begin
            accum_d = '0;
            if (phase_q == PH_WIDTH) begin
              width_d = acc_sum;
              phase_d = PH_HEIGHT;
            end else begin
              height_d   = acc_sum;
              res_hdone  = 1'b1;
              row_cnt_d  = '0;
              line_cnt_d = '0;
              if ((width_q == '0) || (acc_sum == '0)) begin
                res_fdone = 1'b1;
                phase_d   = PH_DONE;
              end else begin
                phase_d = PH_PIXELS;
              end
            end
          end
        end
        PH_PIXELS: begin
          res_byte   = s_axis_tdata;
          res_dvalid = 1'b1;
          if (row_next >= row_bytes) begin
            row_cnt_d  = '0;
            line_cnt_d = line_next;
            if (line_next >= height_q) begin
              res_fdone = 1'b1;
              phase_d   = PH_DONE;
            end
          end else begin
            row_cnt_d = row_next;
          end
        end
        default: begin
          // Done or in error: bytes are ignored until end of stream.
        end
      endcase
      res_status = (phase_d == PH_ERROR) ? err_d : ST_OK;
    end
  end

  // Width and height are shown as their low sixteen bits, values from before
  // any rearm on the same item.
  assign width_ext  = {{OutDimBits{1'b0}}, width_d};
  assign height_ext = {{OutDimBits{1'b0}}, height_d};

  always_comb begin
    if (s_axis_tlast) begin
      res_width  = out_width_sel(width_q);
      res_height = out_width_sel(height_q);
    end else begin
      res_width  = width_ext[OutDimBits-1:0];
      res_height = height_ext[OutDimBits-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_TYPE;
      err_q      <= ST_OK;
      accum_q    <= '0;
      width_q    <= '0;
      height_q   <= '0;
      row_cnt_q  <= '0;
      line_cnt_q <= '0;
    end else if (in_acc) begin
      phase_q    <= phase_d;
      err_q      <= err_d;
      accum_q    <= accum_d;
      width_q    <= width_d;
      height_q   <= height_d;
      row_cnt_q  <= row_cnt_d;
      line_cnt_q <= line_cnt_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_acc) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      out_byte_q   <= res_byte;
      out_dvalid_q <= res_dvalid;
      out_hdone_q  <= res_hdone;
      out_fdone_q  <= res_fdone;
      out_width_q  <= res_width;
      out_height_q <= res_height;
      out_status_q <= res_status;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_height_q, out_width_q, out_byte_q};
  assign m_axis_tuser  = {out_status_q, out_hdone_q, out_dvalid_q};
  assign m_axis_tlast  = out_fdone_q;

endmodule

`default_nettype wire

### hdl/wbmp_dim_acc.sv
// Base-128 digit accumulator for the WBMP width and height fields.
// Depends on wbmp_pkg for the digit width.
`timescale 1ns / 1ps
`default_nettype none

module wbmp_dim_acc
  import wbmp_pkg::*;
#(
  parameter int unsigned DIM_BITS = DimBitsDef
) (
  input  wire logic [DIM_BITS-1:0]  accum_i,
  input  wire logic [DigitBits-1:0] digit_i,
  output logic      [DIM_BITS-1:0]  sum_o,
  output logic                      ovf_o
);

  // Any set bit among the top seven would be shifted out by the next digit.
  assign ovf_o = (accum_i[DIM_BITS-1 -: DigitBits] != '0);
  assign sum_o = {accum_i[DIM_BITS-DigitBits-1:0], digit_i};

endmodule

`default_nettype wire

### hdl/wbmp_chk.sv
// Port-level checker for the WBMP stream parser, bound to the top level.
// Depends on wbmp_pkg for the status codes.
`timescale 1ns / 1ps
`default_nettype none

module wbmp_chk
  import wbmp_pkg::*;
(
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic [7:0]  s_axis_tdata,
  input wire logic        s_axis_tlast,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [39:0] m_axis_tdata,
  input wire logic [4:0]  m_axis_tuser,
  input wire logic        m_axis_tlast
);

  // A waiting result is held unchanged while the receiver stalls.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
    else $error("stalled result changed");

  // The input side is never blocked while the output register is empty.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output register");

  // A pixel byte is never reported together with an error status or the header flag.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser[0]) |->
      (m_axis_tuser[4:2] == ST_OK && !m_axis_tuser[1]))
    else $error("pixel byte with error or header flag");

  // Frame end comes only on a pixel byte or at the end of the header.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tlast) |-> (m_axis_tuser[0] || m_axis_tuser[1]))
    else $error("frame end without pixel or header end");

  // A result that is not a pixel carries a zero byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata[7:0] == 8'h00))
    else $error("non-pixel result with nonzero byte");

endmodule

bind wbmp_stream_parser wbmp_chk u_wbmp_chk (.*);

`default_nettype wire
